// ----- hw/rtl/deq_pkg.sv -----
// Package for the double-ended queue: field widths, opcodes, status codes
// and the memory command struct shared by the controller and the store.
// No dependencies.
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int OPCODE_W = 3;
    localparam int WORD_W   = 32;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 2;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam opcode_t OP_PUSH_FRONT = 3'd0;
    localparam opcode_t OP_PUSH_BACK  = 3'd1;
    localparam opcode_t OP_POP_FRONT  = 3'd2;
    localparam opcode_t OP_POP_BACK   = 3'd3;
    localparam opcode_t OP_CLEAR      = 3'd4;
    localparam opcode_t OP_PEEK       = 3'd5;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

    // Access request from the controller to the entry store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/deq_if.sv -----
// Valid/ready channel interfaces for the double-ended queue.
// Depends on deq_pkg for the field widths.
`default_nettype none

interface deq_in_if;
    logic                             valid;
    logic                             ready;
    deq_pkg::opcode_t                 opcode;
    logic signed [deq_pkg::WORD_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [deq_pkg::WORD_W-1:0] front_value;
    logic signed [deq_pkg::WORD_W-1:0] back_value;
    logic [deq_pkg::TOTAL_W-1:0]       entry_total;
    logic                              is_empty;
    deq_pkg::status_t                  status;

    modport source (output valid, output front_value, output back_value,
                    output entry_total, output is_empty, output status, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input entry_total, input is_empty, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/double_ended_queue_top.sv -----
// Top level of the double-ended queue: controller plus entry store.
// Depends on deq_pkg, deq_if.sv, deq_mem and deq_ctrl.
//
//   Channel  Direction  Handshake    Item contents
//   cmd      in         valid/ready  opcode, push_value
//   rsp      out        valid/ready  front_value, back_value, entry_total,
//                                    is_empty, status
//
// A push, clear, peek, failed operation or a pop that empties the deque
// is answered from the idle state. A pop that leaves entries behind
// passes through a fetch state, during which no new item is taken, as the
// new front or back word comes from the single-port store's registered read.
// Reset clears the indexes and the count at once; the store itself is not
// cleared, and only occupied entries are ever read back.
// A result waits in the output register while rsp is stalled; a new item is
// taken in the same cycle that the waiting result leaves.
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
    input wire logic  clk,
    input wire logic  rst_n,
    deq_in_if.sink    cmd,
    deq_out_if.source rsp
);

    localparam int AW = $clog2(DEPTH);

    // The controller owns every pointer and the cached front and back words,
    // so the store is touched at most once per item: a write on a push, or
    // a read of the entry that becomes the new end on a pop.
    deq_pkg::mem_cmd_t     mem_cmd;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Entries sit in a circular store of DEPTH words.
    deq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/deq_mem.sv -----
// Entry store of the double-ended queue: one synchronous single-port memory
// with a registered read. Depends on deq_pkg for the command struct.
`default_nettype none

module deq_mem #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire deq_pkg::mem_cmd_t     cmd,
    input  wire logic [AW-1:0]         addr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0]      rdata
);

    logic [DATA_WIDTH-1:0] store [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store[addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= store[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/deq_ctrl.sv -----
// Controller of the double-ended queue: head and back indexes, entry count,
// cached end values, result register and memory sequencing.
// Depends on deq_pkg and the channel interfaces in deq_if.sv.
`default_nettype none

module deq_ctrl #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    deq_in_if.sink                     cmd,
    deq_out_if.source                  rsp,
    output deq_pkg::mem_cmd_t          mem_cmd,
    output logic [AW-1:0]              mem_addr,
    output logic [DATA_WIDTH-1:0]      mem_wdata,
    input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;

    localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic                  state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         back_idx_reg, back_idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;
    deq_pkg::status_t      status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  fetch_front_reg, fetch_front_next;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty_now;
    logic [DATA_WIDTH-1:0] word_in;
    logic [AW-1:0]         head_inc, head_dec, back_inc, back_dec;

    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign is_full      = (count_reg == CNT_FULL);
    assign is_empty_now = (count_reg == '0);
    assign word_in      = DATA_WIDTH'(cmd.push_value);

    // Circular index steps; DEPTH need not be a power of two.
    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
    assign back_inc = (back_idx_reg == IDX_LAST) ? '0 : back_idx_reg + 1'b1;
    assign back_dec = (back_idx_reg == '0) ? IDX_LAST : back_idx_reg - 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        back_idx_next    = back_idx_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        fetch_front_next = fetch_front_reg;
        mem_cmd          = '0;
        mem_addr         = head_reg;
        mem_wdata        = word_in;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next    = deq_pkg::ST_OK;
                    out_valid_next = 1'b1;
                    unique case (cmd.opcode)
                        deq_pkg::OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = deq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                head_next     = head_dec;
                                count_next    = count_reg + 1'b1;
                                front_next    = word_in;
                                mem_cmd.wr_en = 1'b1;
                                mem_addr      = head_dec;
                                if (is_empty_now)
                                begin
                                    back_next = word_in;
                                end
                            end
                        end
                        deq_pkg::OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = deq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                back_idx_next = back_inc;
                                count_next    = count_reg + 1'b1;
                                back_next     = word_in;
                                mem_cmd.wr_en = 1'b1;
                                mem_addr      = back_inc;
                                if (is_empty_now)
                                begin
                                    front_next = word_in;
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT:
                        begin
                            if (is_empty_now)
                            begin
                                status_next = deq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                                if (count_reg != CW'(1))
                                begin
                                    // New front comes out of the store next cycle.
                                    mem_cmd.rd_en    = 1'b1;
                                    mem_addr         = head_inc;
                                    fetch_front_next = 1'b1;
                                    out_valid_next   = 1'b0;
                                    state_next       = S_FETCH;
                                end
                            end
                        end
                        deq_pkg::OP_POP_BACK:
                        begin
                            if (is_empty_now)
                            begin
                                status_next = deq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                back_idx_next = back_dec;
                                count_next    = count_reg - 1'b1;
                                if (count_reg != CW'(1))
                                begin
                                    mem_cmd.rd_en    = 1'b1;
                                    mem_addr         = back_dec;
                                    fetch_front_next = 1'b0;
                                    out_valid_next   = 1'b0;
                                    state_next       = S_FETCH;
                                end
                            end
                        end
                        deq_pkg::OP_CLEAR:
                        begin
                            head_next     = '0;
                            back_idx_next = IDX_LAST;
                            count_next    = '0;
                        end
                        default:
                        begin
                            // Peek and the unused opcodes change nothing.
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (fetch_front_reg)
                begin
                    front_next = mem_rdata;
                end
                else
                begin
                    back_next = mem_rdata;
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            back_idx_reg  <= IDX_LAST;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            back_idx_reg  <= back_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg       <= front_next;
        back_reg        <= back_next;
        status_reg      <= status_next;
        fetch_front_reg <= fetch_front_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.is_empty    = (count_reg == '0);
    assign rsp.entry_total = deq_pkg::TOTAL_W'(count_reg);
    assign rsp.status      = status_reg;
    assign rsp.front_value = (count_reg == '0) ? '0
                           : deq_pkg::WORD_W'($signed(front_reg));
    assign rsp.back_value  = (count_reg == '0) ? '0
                           : deq_pkg::WORD_W'($signed(back_reg));

endmodule

`default_nettype wire

// ----- hw/rtl/deq_checker.sv -----
// Port-level checks for the double-ended queue and the bind that attaches
// them to double_ended_queue_top. Depends on deq_pkg.
`default_nettype none

module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [deq_pkg::WORD_W-1:0]  front_value,
    input wire logic [deq_pkg::WORD_W-1:0]  back_value,
    input wire logic [deq_pkg::TOTAL_W-1:0] entry_total,
    input wire logic                        is_empty,
    input wire deq_pkg::status_t            status
);

    // The empty flag agrees with the count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (entry_total == '0)))
        else $error("is_empty disagrees with entry_total");

    // An empty deque shows zero at both ends.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_empty) |-> (front_value == '0 && back_value == '0))
        else $error("empty deque shows a nonzero end value");

    // A dropped push only happens on a full deque.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == deq_pkg::ST_OVERFLOW)
            |-> (entry_total == deq_pkg::TOTAL_W'(DEPTH)))
        else $error("overflow reported on a deque that is not full");

    // An ignored pop only happens on an empty deque.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == deq_pkg::ST_UNDERFLOW) |-> is_empty)
        else $error("underflow reported on a deque that is not empty");

    // A result that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result withdrawn before it was taken");

endmodule

bind double_ended_queue_top deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .front_value (rsp.front_value),
    .back_value  (rsp.back_value),
    .entry_total (rsp.entry_total),
    .is_empty    (rsp.is_empty),
    .status      (rsp.status)
);

`default_nettype wire
